[design/tpcx_pkg.sv]
// Shared types and constants of the triangle plane clip unit.
// No dependencies.
package tpcx_pkg;

    localparam int unsigned WORD_W  = 32;
    localparam int unsigned NUM_W   = 24;
    localparam int unsigned NATTR   = 8;
    localparam int unsigned ADDR_W  = 5;
    localparam int unsigned DEPTH   = 24;
    localparam int unsigned QBITS   = 31;
    localparam int unsigned CFG_W   = 1;
    localparam int unsigned DATA_IW = NATTR * WORD_W;
    localparam int unsigned DATA_OW = NATTR * WORD_W + NUM_W;

    localparam logic [CFG_W-1:0] REG_CUT_X      = 1'd0;
    localparam logic [CFG_W-1:0] REG_KEEP_ABOVE = 1'd1;

    typedef enum logic [1:0] {
        K_CORNER = 2'd0,
        K_CUT    = 2'd1,
        K_REPEAT = 2'd2
    } t_kind;

    typedef struct packed {
        t_kind      kind;
        logic [1:0] ca;
        logic [1:0] cb;
        logic [1:0] off;
        logic       fresh;
        logic       oncut;
        logic       last;
    } t_step;

    typedef enum logic [11:0] {
        S_IDLE = 12'b000000000001,
        S_LOAD = 12'b000000000010,
        S_PLAN = 12'b000000000100,
        S_STEP = 12'b000000001000,
        S_RA   = 12'b000000010000,
        S_RB   = 12'b000000100000,
        S_RC   = 12'b000001000000,
        S_DIV  = 12'b000010000000,
        S_MUL  = 12'b000100000000,
        S_FIN  = 12'b001000000000,
        S_PUSH = 12'b010000000000,
        S_DONE = 12'b100000000000
    } t_state;

endpackage

[design/tpcx_ram.sv]
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module tpcx_ram #(
    parameter int unsigned WIDTH = 32,
    parameter int unsigned DEPTH = 24
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

[design/triangle_plane_clip_x_unit.sv]
// Top level of the triangle plane clip unit: corner store, sequencer, serial divider
// and multiplier. Depends on tpcx_pkg and tpcx_ram.
//
// A vertex item is written into the corner store one word per cycle, and the block takes
// a new vertex only once the last one is stored and no triangle is in work. The third
// corner starts the triangle after a planning state; a triangle fully outside then ends
// with no output. A cut vertex takes a 31-step serial divide for the ratio, then seven
// 31-step serial multiplies, each after two store reads; a repeated cut vertex is sent
// again without store reads. Results leave through an output register, so the next
// vertices are taken while the last output vertex waits.
module triangle_plane_clip_x_unit #(
    parameter int unsigned COORD_WIDTH = 32,
    parameter int unsigned INDEX_BITS  = 24
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_s_axis_tvalid,
    output logic                              o_s_axis_tready,
    // pos_x, pos_y, pos_z, norm_x, norm_y, norm_z, tex_u, tex_v
    input  logic [tpcx_pkg::DATA_IW-1:0]      i_s_axis_tdata,
    // start_mesh
    input  logic                              i_s_axis_tuser,
    output logic                              o_m_axis_tvalid,
    input  logic                              i_m_axis_tready,
    // out_pos_x, out_pos_y, out_pos_z, out_norm_x, out_norm_y, out_norm_z,
    // out_tex_u, out_tex_v, vertex_number
    output logic [tpcx_pkg::DATA_OW-1:0]      o_m_axis_tdata,
    // is_new_vertex, on_cut_line
    output logic [1:0]                        o_m_axis_tuser,
    output logic                              o_m_axis_tlast,
    input  logic                              i_cfg_valid,
    output logic                              o_cfg_ready,
    input  logic [tpcx_pkg::CFG_W-1:0]        i_cfg_index,
    input  logic [tpcx_pkg::WORD_W-1:0]       i_cfg_data
);

    localparam int unsigned CW = COORD_WIDTH;
    localparam int unsigned PW = CW + 1 + tpcx_pkg::QBITS;

    tpcx_pkg::t_state r_state, n_state;

    logic signed [CW-1:0]   r_cut;
    logic                   r_keep;
    logic [1:0]             r_count;
    logic [1:0]             r_slot;
    logic [INDEX_BITS-1:0]  r_next;
    logic [INDEX_BITS-1:0]  r_base;
    logic [CW-1:0]          r_in   [tpcx_pkg::NATTR];
    logic signed [CW-1:0]   r_cx   [3];
    logic [2:0]             r_w;
    logic [1:0]             r_nin;
    logic [1:0]             r_sel;
    logic [2:0]             r_step;
    logic [CW-1:0]          r_obuf [tpcx_pkg::NATTR];
    logic signed [CW-1:0]   r_av;
    logic [CW+1:0]          r_rem;
    logic [CW:0]            r_den;
    logic [tpcx_pkg::QBITS-1:0] r_q, r_ms;
    logic [4:0]             r_cnt;
    logic [CW:0]            r_mag;
    logic                   r_neg;
    logic [PW-1:0]          r_acc;
    logic                   r_ovalid;
    logic [tpcx_pkg::DATA_OW-1:0] r_odata;
    logic [1:0]             r_ouser;
    logic                   r_olast;

    logic                   s_acc;
    logic                   m_free;
    logic                   we;
    logic [tpcx_pkg::ADDR_W-1:0] waddr, raddr;
    logic [CW-1:0]          rdata;
    tpcx_pkg::t_step        st;
    logic [2:0]             ins;
    logic [1:0]             nin;
    logic [1:0]             sel;
    logic signed [CW:0]     diff;
    logic [CW+1:0]          rem_sub;
    logic [PW-30:0]         delta_w;
    logic [CW-1:0]          delta;

    function automatic logic [1:0] nxt3(input logic [1:0] k);
        return (k == 2'd2) ? 2'd0 : k + 2'd1;
    endfunction

    assign s_acc           = i_s_axis_tvalid && o_s_axis_tready;
    assign o_s_axis_tready = (r_state == tpcx_pkg::S_IDLE);
    assign o_cfg_ready     = 1'b1;
    assign m_free          = !r_ovalid || i_m_axis_tready;

    always_comb begin
        for (int k = 0; k < 3; k++) begin
            ins[k] = r_keep ? (r_cx[k] > r_cut) : (r_cx[k] < r_cut);
        end
        nin = 2'(ins[0]) + 2'(ins[1]) + 2'(ins[2]);
        sel = 2'd0;
        if (nin == 2'd2) begin
            sel = !ins[0] ? 2'd0 : (!ins[1] ? 2'd1 : 2'd2);
        end else if (nin == 2'd1) begin
            sel = ins[0] ? 2'd0 : (ins[1] ? 2'd1 : 2'd2);
        end
    end

    always_comb begin
        st = '{kind: tpcx_pkg::K_CORNER, ca: r_step[1:0], cb: 2'd0, off: r_step[1:0],
               fresh: 1'b1, oncut: 1'b0, last: (r_step == 3'd2)};
        if (r_nin == 2'd2) begin
            case (r_step)
                3'd0: st = '{tpcx_pkg::K_CORNER, nxt3(r_sel), 2'd0, 2'd0, 1'b1, 1'b0, 1'b0};
                3'd1: st = '{tpcx_pkg::K_CORNER, nxt3(nxt3(r_sel)), 2'd0, 2'd1,
                             1'b1, 1'b0, 1'b0};
                3'd2: st = '{tpcx_pkg::K_CUT, nxt3(nxt3(r_sel)), r_sel, 2'd2,
                             1'b1, 1'b1, 1'b0};
                3'd3: st = '{tpcx_pkg::K_REPEAT, 2'd0, 2'd0, 2'd2, 1'b0, 1'b1, 1'b0};
                3'd4: st = '{tpcx_pkg::K_CUT, nxt3(r_sel), r_sel, 2'd3, 1'b1, 1'b1, 1'b0};
                default: st = '{tpcx_pkg::K_CORNER, nxt3(r_sel), 2'd0, 2'd0,
                                1'b0, 1'b0, 1'b1};
            endcase
        end else if (r_nin == 2'd1) begin
            case (r_step)
                3'd0: st = '{tpcx_pkg::K_CORNER, r_sel, 2'd0, 2'd0, 1'b1, 1'b0, 1'b0};
                3'd1: st = '{tpcx_pkg::K_CUT, r_sel, nxt3(nxt3(r_sel)), 2'd1,
                             1'b1, 1'b1, 1'b0};
                default: st = '{tpcx_pkg::K_CUT, r_sel, nxt3(r_sel), 2'd2,
                                1'b1, 1'b1, 1'b1};
            endcase
        end
    end

    assign we    = (r_state == tpcx_pkg::S_LOAD);
    assign waddr = {r_slot, r_w};
    assign raddr = (r_state == tpcx_pkg::S_RB) ? {st.cb, r_w} : {st.ca, r_w};

    tpcx_ram #(
        .WIDTH (CW),
        .DEPTH (tpcx_pkg::DEPTH)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (we),
        .i_waddr (waddr),
        .i_wdata (r_in[0]),
        .i_raddr (raddr),
        .o_rdata (rdata)
    );

    assign diff    = (r_state == tpcx_pkg::S_RC && r_w == 3'd0)
                     ? ((CW+1)'(r_av) - (CW+1)'(r_cut))
                     : ((CW+1)'($signed(rdata)) - (CW+1)'(r_av));
    assign rem_sub = r_rem - (CW+2)'(r_den);
    assign delta_w = (PW-29)'((r_acc + (PW)'(1 << 29)) >> 30);
    assign delta   = CW'(delta_w);

    always_comb begin
        n_state = r_state;
        case (r_state)
            tpcx_pkg::S_IDLE: if (s_acc) n_state = tpcx_pkg::S_LOAD;
            tpcx_pkg::S_LOAD: begin
                if (r_w == 3'd7) begin
                    n_state = (r_slot == 2'd2) ? tpcx_pkg::S_PLAN : tpcx_pkg::S_IDLE;
                end
            end
            tpcx_pkg::S_PLAN: n_state = (nin == 2'd0) ? tpcx_pkg::S_IDLE : tpcx_pkg::S_STEP;
            tpcx_pkg::S_STEP: begin
                case (st.kind)
                    tpcx_pkg::K_REPEAT: n_state = tpcx_pkg::S_PUSH;
                    default:            n_state = tpcx_pkg::S_RA;
                endcase
            end
            tpcx_pkg::S_RA: n_state = tpcx_pkg::S_RB;
            tpcx_pkg::S_RB: begin
                if (st.kind == tpcx_pkg::K_CORNER) begin
                    n_state = (r_w == 3'd7) ? tpcx_pkg::S_PUSH : tpcx_pkg::S_RA;
                end else begin
                    n_state = tpcx_pkg::S_RC;
                end
            end
            tpcx_pkg::S_RC: n_state = (r_w == 3'd0) ? tpcx_pkg::S_DIV : tpcx_pkg::S_MUL;
            tpcx_pkg::S_DIV: if (r_cnt == 5'd30) n_state = tpcx_pkg::S_RA;
            tpcx_pkg::S_MUL: if (r_cnt == 5'd30) n_state = tpcx_pkg::S_FIN;
            tpcx_pkg::S_FIN: n_state = (r_w == 3'd7) ? tpcx_pkg::S_PUSH : tpcx_pkg::S_RA;
            tpcx_pkg::S_PUSH: begin
                if (m_free) n_state = st.last ? tpcx_pkg::S_IDLE : tpcx_pkg::S_DONE;
            end
            tpcx_pkg::S_DONE: n_state = tpcx_pkg::S_STEP;
            default: n_state = tpcx_pkg::S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= tpcx_pkg::S_IDLE;
            r_cut    <= '0;
            r_keep   <= 1'b0;
            r_count  <= 2'd0;
            r_next   <= '0;
            r_ovalid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (i_cfg_valid) begin
                case (i_cfg_index)
                    tpcx_pkg::REG_CUT_X:      r_cut  <= i_cfg_data[CW-1:0];
                    tpcx_pkg::REG_KEEP_ABOVE: r_keep <= i_cfg_data[0];
                    default: ;
                endcase
            end
            if (s_acc) begin
                if (i_s_axis_tuser) begin
                    r_next  <= '0;
                    r_count <= 2'd1;
                end else begin
                    r_count <= (r_count == 2'd2) ? 2'd0 : r_count + 2'd1;
                end
            end
            if (r_state == tpcx_pkg::S_PLAN && nin != 2'd0) begin
                r_next <= r_next + INDEX_BITS'((nin == 2'd2) ? 3'd4 : 3'd3);
            end
            if (r_state == tpcx_pkg::S_PUSH && m_free) begin
                r_ovalid <= 1'b1;
            end else if (i_m_axis_tready) begin
                r_ovalid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        case (r_state)
            tpcx_pkg::S_IDLE: begin
                r_w <= 3'd0;
                if (s_acc) begin
                    r_slot <= i_s_axis_tuser ? 2'd0 : r_count;
                    for (int j = 0; j < tpcx_pkg::NATTR; j++) begin
                        r_in[j] <= i_s_axis_tdata[j*tpcx_pkg::WORD_W +: CW];
                    end
                end
            end
            tpcx_pkg::S_LOAD: begin
                if (r_w == 3'd0) r_cx[r_slot] <= r_in[0];
                for (int j = 0; j < tpcx_pkg::NATTR - 1; j++) r_in[j] <= r_in[j+1];
                r_w <= r_w + 3'd1;
            end
            tpcx_pkg::S_PLAN: begin
                r_nin  <= nin;
                r_sel  <= sel;
                r_step <= 3'd0;
                r_base <= r_next;
            end
            tpcx_pkg::S_STEP: r_w <= 3'd0;
            tpcx_pkg::S_RB: begin
                if (st.kind == tpcx_pkg::K_CORNER) begin
                    for (int j = 0; j < tpcx_pkg::NATTR - 1; j++) r_obuf[j] <= r_obuf[j+1];
                    r_obuf[tpcx_pkg::NATTR-1] <= rdata;
                    r_w <= r_w + 3'd1;
                end else begin
                    r_av <= rdata;
                end
            end
            tpcx_pkg::S_RC: begin
                r_cnt <= 5'd0;
                r_acc <= '0;
                r_ms  <= r_q;
                if (r_w == 3'd0) begin
                    r_rem <= (CW+2)'(diff[CW] ? -diff : diff);
                    r_den <= (CW+1)'($signed(rdata) > r_av ? (CW+1)'($signed(rdata))
                             - (CW+1)'(r_av) : (CW+1)'(r_av) - (CW+1)'($signed(rdata)));
                    r_q   <= '0;
                end else begin
                    r_mag <= diff[CW] ? (CW+1)'(-diff) : (CW+1)'(diff);
                    r_neg <= diff[CW];
                end
            end
            tpcx_pkg::S_DIV: begin
                r_cnt <= r_cnt + 5'd1;
                if (!rem_sub[CW+1]) begin
                    r_rem <= {rem_sub[CW:0], 1'b0};
                    r_q   <= {r_q[tpcx_pkg::QBITS-2:0], 1'b1};
                end else begin
                    r_rem <= {r_rem[CW:0], 1'b0};
                    r_q   <= {r_q[tpcx_pkg::QBITS-2:0], 1'b0};
                end
                if (r_cnt == 5'd30) begin
                    for (int j = 0; j < tpcx_pkg::NATTR - 1; j++) r_obuf[j] <= r_obuf[j+1];
                    r_obuf[tpcx_pkg::NATTR-1] <= r_cut;
                    r_w <= 3'd1;
                end
            end
            tpcx_pkg::S_MUL: begin
                r_cnt <= r_cnt + 5'd1;
                r_acc <= {r_acc[PW-2:0], 1'b0}
                         + (r_ms[tpcx_pkg::QBITS-1] ? PW'(r_mag) : '0);
                r_ms  <= {r_ms[tpcx_pkg::QBITS-2:0], 1'b0};
            end
            tpcx_pkg::S_FIN: begin
                for (int j = 0; j < tpcx_pkg::NATTR - 1; j++) r_obuf[j] <= r_obuf[j+1];
                r_obuf[tpcx_pkg::NATTR-1] <= r_neg ? r_av - delta : r_av + delta;
                r_w <= r_w + 3'd1;
            end
            tpcx_pkg::S_PUSH: begin
                if (m_free) begin
                    for (int j = 0; j < tpcx_pkg::NATTR; j++) begin
                        r_odata[j*tpcx_pkg::WORD_W +: tpcx_pkg::WORD_W] <=
                            tpcx_pkg::WORD_W'($signed(r_obuf[j]));
                    end
                    r_odata[tpcx_pkg::DATA_IW +: tpcx_pkg::NUM_W] <=
                        tpcx_pkg::NUM_W'(r_base + INDEX_BITS'(st.off));
                    r_ouser <= {st.oncut, st.fresh};
                    r_olast <= st.last;
                end
            end
            tpcx_pkg::S_DONE: r_step <= r_step + 3'd1;
            default: ;
        endcase
    end

    assign o_m_axis_tvalid = r_ovalid;
    assign o_m_axis_tdata  = r_odata;
    assign o_m_axis_tuser  = r_ouser;
    assign o_m_axis_tlast  = r_olast;

endmodule

[design/tpcx_checker.sv]
// Port-level checks of the triangle plane clip unit, bound to its top level.
// Depends on tpcx_pkg.
module tpcx_checker (
    input logic                         i_clk,
    input logic                         i_rst_n,
    input logic                         o_m_axis_tvalid,
    input logic                         i_m_axis_tready,
    input logic [tpcx_pkg::DATA_OW-1:0] o_m_axis_tdata,
    input logic [1:0]                   o_m_axis_tuser,
    input logic                         o_m_axis_tlast
);

    a_reset_quiet: assert property (@(posedge i_clk) !i_rst_n |=> !o_m_axis_tvalid)
        else $error("output valid after reset");

    a_hold_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && !i_m_axis_tready |=> o_m_axis_tvalid)
        else $error("output item dropped while stalled");

    a_hold_data: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && !i_m_axis_tready |=> $stable(o_m_axis_tdata))
        else $error("output item changed while stalled");

    a_reuse_flags: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && !o_m_axis_tuser[0] |-> (o_m_axis_tuser[1] != o_m_axis_tlast))
        else $error("reused vertex with wrong flags");

    a_cut_new: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && o_m_axis_tuser[1] && o_m_axis_tlast |-> o_m_axis_tuser[0])
        else $error("closing cut vertex not new");

endmodule

bind triangle_plane_clip_x_unit tpcx_checker u_tpcx_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .o_m_axis_tvalid (o_m_axis_tvalid),
    .i_m_axis_tready (i_m_axis_tready),
    .o_m_axis_tdata  (o_m_axis_tdata),
    .o_m_axis_tuser  (o_m_axis_tuser),
    .o_m_axis_tlast  (o_m_axis_tlast)
);
